// ===== hdl/wpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int PATTERN_MAX    = 32;
    localparam int VEC_W          = PATTERN_MAX + 1;
    localparam int IDX_W          = $clog2(VEC_W);
    localparam int CLOSURE_LEVELS = $clog2(VEC_W);

    localparam int WORD_COUNT = 4;
    localparam int WORD_W     = 64;
    localparam int WORD_BYTES = WORD_W / 8;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [7:0] ANY_ONE = 8'h25;   // '%'
    localparam logic [7:0] ANY_RUN = 8'h2A;   // '*'

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

    typedef logic [VEC_W-1:0]            t_vec;
    typedef logic [PATTERN_MAX-1:0][7:0] t_pat_bytes;

    typedef struct packed {
        logic [7:0] candidate_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_candidate;
    } t_item;

    typedef struct packed {
        t_vec next_prefixes;
        logic has_result;
        logic matched;
    } t_step;

endpackage
`default_nettype wire

// ===== hdl/wpm_closure.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_closure
// Star closure of a prefix vector as a parallel prefix scan.
// ----------------------------------------------------------------------------
module wpm_closure (
    input  wire wpm_pkg::t_vec                        i_vec,
    input  wire logic [wpm_pkg::PATTERN_MAX-1:0]      i_star,
    output wpm_pkg::t_vec                             o_vec
);
    import wpm_pkg::*;

    // bit j is set when bit j-1 is set and pattern byte j-1 is a star
    t_vec w_g [CLOSURE_LEVELS+1];
    t_vec w_p [CLOSURE_LEVELS];

    assign w_g[0] = i_vec;
    assign w_p[0] = {i_star, 1'b0};

    for (genvar l = 0; l < CLOSURE_LEVELS; l++) begin : g_level
        localparam int D = 1 << l;
        for (genvar j = 0; j < VEC_W; j++) begin : g_bit
            if (j >= D) begin : g_comb
                assign w_g[l+1][j] = w_g[l][j] | (w_p[l][j] & w_g[l][j-D]);
                if (l + 1 < CLOSURE_LEVELS) begin : g_prop
                    assign w_p[l+1][j] = w_p[l][j] & w_p[l][j-D];
                end
            end else begin : g_copy
                assign w_g[l+1][j] = w_g[l][j];
                if (l + 1 < CLOSURE_LEVELS) begin : g_prop
                    assign w_p[l+1][j] = w_p[l][j];
                end
            end
        end
    end

    assign o_vec = w_g[CLOSURE_LEVELS];

endmodule
`default_nettype wire

// ===== hdl/wpm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpm_core
// One candidate byte against the prefix vector: closure, shift, closure.
// ----------------------------------------------------------------------------
module wpm_core (
    input  wire wpm_pkg::t_pat_bytes              i_pat,
    input  wire logic [wpm_pkg::IDX_W-1:0]        i_len,
    input  wire wpm_pkg::t_vec                    i_prefixes,
    input  wire wpm_pkg::t_item                   i_item,
    output wpm_pkg::t_step                        o_step
);
    import wpm_pkg::*;

    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_hit;
    t_vec                   w_base;
    t_vec                   w_cur;
    t_vec                   w_raw;
    t_vec                   w_nxt;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_byte
        assign w_star[i] = (i_pat[i] == ANY_RUN);
        assign w_hit[i]  = (i_pat[i] == i_item.candidate_byte) || (i_pat[i] == ANY_ONE);
    end

    // restart from the empty prefix on a new or empty candidate
    assign w_base = (i_item.first_byte || i_item.empty_candidate) ? VEC_W'(1) : i_prefixes;

    wpm_closure u_cur (
        .i_vec  (w_base),
        .i_star (w_star),
        .o_vec  (w_cur)
    );

    assign w_raw = {(w_cur[PATTERN_MAX-1:0] & w_hit) | (w_cur[VEC_W-1:1] & w_star), 1'b0};

    wpm_closure u_nxt (
        .i_vec  (w_raw),
        .i_star (w_star),
        .o_vec  (w_nxt)
    );

    always_comb begin
        o_step.has_result = i_item.last_byte || i_item.empty_candidate;
        if (i_item.empty_candidate) begin
            o_step.matched = w_cur[i_len];
        end else begin
            o_step.matched = w_nxt[i_len];
        end
        if (o_step.has_result) begin
            o_step.next_prefixes = VEC_W'(1);
        end else begin
            o_step.next_prefixes = w_nxt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wildcard_pattern_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_pattern_match
// Streams candidate bytes against a glob pattern ('*' any run, '%' one byte).
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  -------------------------------
//  input     in   i_in_valid / o_in_stall   candidate_byte, first_byte,
//                                            last_byte, empty_candidate
//  output    out  o_out_valid / i_out_stall matched
//  config    in   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One item is taken every cycle unless a result item waits on a stalled
//  output. An item passes the input register, one pass through the
//  closure/shift/closure logic and the result register before its result
//  is offered.
//  Reset (synchronous, active low) clears the pattern and length and sets the
//  prefix vector to the empty prefix; no clearing pass is needed.
//  A stall on the output holds only items that carry a result; other bytes
//  keep flowing into the prefix vector.
// ----------------------------------------------------------------------------
module wildcard_pattern_match (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic [7:0]                        i_candidate_byte,
    input  wire logic                              i_first_byte,
    input  wire logic                              i_last_byte,
    input  wire logic                              i_empty_candidate,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic                              o_matched,
    input  wire logic                              i_cfg_we,
    input  wire logic [wpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wpm_pkg::WORD_W-1:0]        i_cfg_data
);
    import wpm_pkg::*;

    // configuration
    logic [WORD_W-1:0] r_pattern_word [WORD_COUNT];
    logic [LEN_W-1:0]  r_pattern_length;

    // input register
    logic  r_s1_valid;
    t_item r_s1_item;

    // match state and result register
    t_vec  r_prefix;
    logic  r_out_valid;
    logic  r_matched;

    t_pat_bytes       w_pat;
    logic [IDX_W-1:0] w_len;
    t_step            w_step;
    logic             w_out_free;
    logic             w_s1_go;
    logic             w_s1_load;

    // unpack pattern bytes, lowest byte first; bytes past the last word read zero
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
        if (i < WORD_COUNT * WORD_BYTES) begin : g_word
            assign w_pat[i] = r_pattern_word[i / WORD_BYTES][8 * (i % WORD_BYTES) +: 8];
        end else begin : g_zero
            assign w_pat[i] = 8'h00;
        end
    end

    // clamp an over-long length to the pattern capacity
    assign w_len = (r_pattern_length > LEN_W'(PATTERN_MAX))
                 ? IDX_W'(PATTERN_MAX) : IDX_W'(r_pattern_length);

    wpm_core u_core (
        .i_pat      (w_pat),
        .i_len      (w_len),
        .i_prefixes (r_prefix),
        .i_item     (r_s1_item),
        .o_step     (w_step)
    );

    // result slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_go    = r_s1_valid && (!w_step.has_result || w_out_free);
    assign w_s1_load  = !r_s1_valid || w_s1_go;
    assign o_in_stall = !w_s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORD_COUNT; k++) begin
                r_pattern_word[k] <= '0;
            end
            r_pattern_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_WORD_0: r_pattern_word[0] <= i_cfg_data;
                CFG_PATTERN_WORD_1: r_pattern_word[1] <= i_cfg_data;
                CFG_PATTERN_WORD_2: r_pattern_word[2] <= i_cfg_data;
                CFG_PATTERN_WORD_3: r_pattern_word[3] <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // take a new item whenever the input register empties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_in_valid) begin
            r_s1_item.candidate_byte  <= i_candidate_byte;
            r_s1_item.first_byte      <= i_first_byte;
            r_s1_item.last_byte       <= i_last_byte;
            r_s1_item.empty_candidate <= i_empty_candidate;
        end
    end

    // advance the prefix vector; a result returns it to the empty prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= VEC_W'(1);
        end else if (w_s1_go) begin
            r_prefix <= w_step.next_prefixes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_go && w_step.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s1_go && w_step.has_result) begin
            r_matched <= w_step.matched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;

    // a result always leaves the vector at the empty prefix
    a_prefix_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_step.has_result |=> r_prefix == VEC_W'(1))
        else $error("prefix vector not restarted after a result");

    // stall only with an item held in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with no item held");

    // a finished result item reaches the output register
    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_step.has_result |=> o_out_valid)
        else $error("result item lost");

    // a result item must wait while the output is blocked
    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_step.has_result && r_out_valid && i_out_stall |-> o_in_stall)
        else $error("result item advanced into a blocked output");

endmodule
`default_nettype wire
